### src/cfwu_pkg.sv
// Shared types and constants of the CAN firmware update receiver.
package cfwu_pkg;

    localparam logic [3:0] CMD_UPDATE = 4'hc;
    localparam logic [7:0] ERR_BYTE   = 8'hee;
    localparam logic [6:0] NODE_RESET = 7'h7f;

    localparam logic [3:0] CH_CONNECT = 4'd0;
    localparam logic [3:0] CH_PAGE    = 4'd1;
    localparam logic [3:0] CH_DATA    = 4'd2;
    localparam logic [3:0] CH_END     = 4'd3;
    localparam logic [3:0] CH_DONE    = 4'd4;

    localparam logic [1:0] KIND_BUF_WRITE = 2'd0;
    localparam logic [1:0] KIND_TRANSMIT  = 2'd1;
    localparam logic [1:0] KIND_COMMIT    = 2'd2;

    localparam logic [1:0] PH_WAITING = 2'd0;
    localparam logic [1:0] PH_STARTED = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [28:0] tx_ext_id;
        logic        tx_dlc;
        logic [7:0]  tx_byte;
        logic [6:0]  buf_slot;
        logic [63:0] buf_word;
        logic [31:0] commit_addr;
        logic [1:0]  update_phase;
        logic        last;
    } t_result;

    typedef struct packed {
        logic        is_extended;
        logic        is_data_frame;
        logic [28:0] ext_id;
        logic [3:0]  dlc;
        logic [63:0] payload;
    } t_frame;

endpackage

### src/cfwu_frame_if.sv
// Handshake channel that carries received CAN frames.
interface cfwu_frame_if;
    logic        valid;
    logic        ready;
    logic        is_extended;
    logic        is_data_frame;
    logic [28:0] ext_id;
    logic [3:0]  dlc;
    logic [63:0] payload;

    modport source (
        output valid, is_extended, is_data_frame, ext_id, dlc, payload,
        input  ready
    );
    modport sink (
        input  valid, is_extended, is_data_frame, ext_id, dlc, payload,
        output ready
    );
endinterface

### src/cfwu_result_if.sv
// Handshake channel that carries result words of the update receiver.
interface cfwu_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [28:0] tx_ext_id;
    logic        tx_dlc;
    logic [7:0]  tx_byte;
    logic [6:0]  buf_slot;
    logic [63:0] buf_word;
    logic [31:0] commit_addr;
    logic [1:0]  update_phase;
    logic        last;

    modport source (
        output valid, kind, tx_ext_id, tx_dlc, tx_byte, buf_slot, buf_word,
               commit_addr, update_phase, last,
        input  ready
    );
    modport sink (
        input  valid, kind, tx_ext_id, tx_dlc, tx_byte, buf_slot, buf_word,
               commit_addr, update_phase, last,
        output ready
    );
endinterface

### src/can_firmware_update_receiver.sv
// Top level of the CAN firmware update receiver.
//
//   channel    direction  word
//   i_frame    in         one received CAN frame (flags, 29-bit id, dlc, payload)
//   o_result   out        one result: buffer word write, reply frame or page commit
//   i_cfg_*    in         write of the application base address
//
// A frame is taken into an input register and handled from there, with the
// result word loaded into the output register, so one frame per cycle is
// sustained while the output is not stalled. A page end that commits yields
// two words (commit, then acknowledge) through the single output register and
// so holds the input register until the acknowledge is loaded into the output
// register. Frames that cause no word leave even while the output is stalled.
// Reset is synchronous and active low; it restores node address 127, phase waiting and zero counts.
module can_firmware_update_receiver (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [31:0]           i_cfg_wr_data,
    cfwu_frame_if.sink            i_frame,
    cfwu_result_if.source         o_result
);

    // Input register holding the frame under work.
    logic                   r_in_valid;
    cfwu_pkg::t_frame       r_in;

    // Output register holding the word on offer.
    logic                   r_out_valid;
    cfwu_pkg::t_result      r_out;

    // Set while the acknowledge that follows a commit is still to be sent.
    logic                   r_sub;

    // Update state.
    logic [31:0]            r_app_base;
    logic [6:0]             r_node_addr,  n_node_addr;
    logic [31:0]            r_page_addr,  n_page_addr;
    logic [31:0]            r_last_wr,    n_last_wr;
    logic [7:0]             r_frame_cnt,  n_frame_cnt;
    logic [15:0]            r_page_sum,   n_page_sum;
    logic [1:0]             r_phase,      n_phase;

    // Work of the current cycle.
    cfwu_pkg::t_result      w_res;
    logic                   w_emit;     // a word is produced this cycle
    logic                   w_split;    // a second word still follows
    logic                   w_go;
    logic                   w_done;
    logic                   w_out_free;
    logic                   w_in_ready;

    logic [6:0]             w_slot;
    logic [3:0]             w_chan;
    logic [6:0]             w_dst;
    logic [3:0]             w_cmd;
    logic                   w_act;
    logic [10:0]            w_byte_sum;
    logic                   w_good;
    logic                   w_commit;

    assign w_slot = r_in.ext_id[6:0];
    assign w_chan = r_in.ext_id[10:7];
    assign w_dst  = r_in.ext_id[17:11];
    assign w_cmd  = r_in.ext_id[21:18];
    assign w_act  = r_in.is_extended && r_in.is_data_frame &&
                    (w_cmd == cfwu_pkg::CMD_UPDATE);

    // Sum of the eight payload bytes; eight narrow adds.
    always_comb begin
        w_byte_sum = '0;
        for (int k = 0; k < 8; k++) begin
            w_byte_sum = w_byte_sum + {3'b000, r_in.payload[8*k +: 8]};
        end
    end

    // Page end checks: checksum in bytes 2 and 3, frame count in byte 1.
    assign w_good   = (r_in.payload[47:32] == r_page_sum) &&
                      (r_in.payload[55:48] == r_frame_cnt);
    assign w_commit = (r_page_addr > r_last_wr) && (r_page_addr >= r_app_base);

    always_comb begin
        n_node_addr = r_node_addr;
        n_page_addr = r_page_addr;
        n_last_wr   = r_last_wr;
        n_frame_cnt = r_frame_cnt;
        n_page_sum  = r_page_sum;
        n_phase     = r_phase;
        w_emit      = 1'b0;
        w_split     = 1'b0;
        w_res       = '0;

        if (r_sub) begin
            // Acknowledge after a commit; the state was updated with the commit.
            w_emit       = 1'b1;
            w_res.kind   = cfwu_pkg::KIND_TRANSMIT;
            w_res.last   = 1'b1;
        end else if (w_act) begin
            case (w_chan)
                cfwu_pkg::CH_CONNECT: begin
                    n_node_addr = w_dst;
                    n_last_wr   = '0;
                    n_phase     = cfwu_pkg::PH_STARTED;
                    w_emit      = 1'b1;
                    w_res.kind  = cfwu_pkg::KIND_TRANSMIT;
                    w_res.last  = 1'b1;
                end
                cfwu_pkg::CH_PAGE: begin
                    n_page_addr = r_in.payload[63:32];
                    n_frame_cnt = '0;
                    n_page_sum  = '0;
                    w_emit      = 1'b1;
                    w_res.kind  = cfwu_pkg::KIND_TRANSMIT;
                    w_res.last  = 1'b1;
                end
                cfwu_pkg::CH_DATA: begin
                    n_page_sum     = r_page_sum + {5'b00000, w_byte_sum};
                    n_frame_cnt    = r_frame_cnt + 8'd1;
                    w_emit         = 1'b1;
                    w_res.kind     = cfwu_pkg::KIND_BUF_WRITE;
                    w_res.buf_slot = w_slot;
                    w_res.buf_word = r_in.payload;
                    w_res.last     = 1'b1;
                end
                cfwu_pkg::CH_END: begin
                    if (r_frame_cnt != '0) begin
                        w_emit = 1'b1;
                        if (w_good && w_commit) begin
                            n_last_wr         = r_page_addr;
                            w_split           = 1'b1;
                            w_res.kind        = cfwu_pkg::KIND_COMMIT;
                            w_res.commit_addr = r_page_addr;
                        end else if (w_good) begin
                            w_res.kind = cfwu_pkg::KIND_TRANSMIT;
                            w_res.last = 1'b1;
                        end else begin
                            w_res.kind    = cfwu_pkg::KIND_TRANSMIT;
                            w_res.tx_dlc  = 1'b1;
                            w_res.tx_byte = cfwu_pkg::ERR_BYTE;
                            w_res.last    = 1'b1;
                        end
                    end
                end
                cfwu_pkg::CH_DONE: begin
                    n_phase    = cfwu_pkg::PH_DONE;
                    w_emit     = 1'b1;
                    w_res.kind = cfwu_pkg::KIND_TRANSMIT;
                    w_res.last = 1'b1;
                end
                default: begin
                    w_emit = 1'b0;
                end
            endcase
        end

        // Reply id: own node address, same command, destination 0, same
        // channel and slot. The connect reply already carries the new address.
        if (w_res.kind == cfwu_pkg::KIND_TRANSMIT) begin
            w_res.tx_ext_id = {n_node_addr, cfwu_pkg::CMD_UPDATE, 7'd0, w_chan, w_slot};
        end
        w_res.update_phase = n_phase;
    end

    // A frame moves on when its word fits in the output register; a frame
    // that yields nothing never waits for the output.
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_go       = r_in_valid && (!w_emit || w_out_free);
    assign w_done     = w_go && !w_split;
    assign w_in_ready = !r_in_valid || w_done;

    assign i_frame.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sub       <= 1'b0;
            r_app_base  <= '0;
            r_node_addr <= cfwu_pkg::NODE_RESET;
            r_page_addr <= '0;
            r_last_wr   <= '0;
            r_frame_cnt <= '0;
            r_page_sum  <= '0;
            r_phase     <= cfwu_pkg::PH_WAITING;
        end else begin
            if (i_cfg_wr_en) begin
                r_app_base <= i_cfg_wr_data;
            end
            if (w_in_ready) begin
                r_in_valid <= i_frame.valid;
            end
            if (w_go) begin
                r_sub       <= w_split;
                r_node_addr <= n_node_addr;
                r_page_addr <= n_page_addr;
                r_last_wr   <= n_last_wr;
                r_frame_cnt <= n_frame_cnt;
                r_page_sum  <= n_page_sum;
                r_phase     <= n_phase;
            end
            if (w_go && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_ready) begin
            r_in.is_extended   <= i_frame.is_extended;
            r_in.is_data_frame <= i_frame.is_data_frame;
            r_in.ext_id        <= i_frame.ext_id;
            r_in.dlc           <= i_frame.dlc;
            r_in.payload       <= i_frame.payload;
        end
        if (w_go && w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.kind         = r_out.kind;
    assign o_result.tx_ext_id    = r_out.tx_ext_id;
    assign o_result.tx_dlc       = r_out.tx_dlc;
    assign o_result.tx_byte      = r_out.tx_byte;
    assign o_result.buf_slot     = r_out.buf_slot;
    assign o_result.buf_word     = r_out.buf_word;
    assign o_result.commit_addr  = r_out.commit_addr;
    assign o_result.update_phase = r_out.update_phase;
    assign o_result.last         = r_out.last;

endmodule
